@@ hw/rtl/playfair_digraph_cipher_defines.svh @@
// ---------------------------------------------------------------------------
// Playfair digraph cipher: assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// Condition holds at every edge outside reset.
`define PF_ASSERT_HOLDS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PF_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pf_pkg.sv @@
// ---------------------------------------------------------------------------
// pf_pkg
// Types, constants and small helper functions of the Playfair cipher.
// ---------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

  localparam int SIDE     = 5;
  localparam int CELLS    = 25;
  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [4:0]          cell_t;
  typedef logic [2:0]          coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;

  typedef enum logic [1:0] {
    CMD_KEY = 2'd0,
    CMD_ENC = 2'd1,
    CMD_DEC = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_SQ
  } state_t;

  // Clamp codes above z to z, fold j into i.
  function automatic letter_t norm_letter(input letter_t raw);
    letter_t l;
    l = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (l == LETTER_J) begin
      l = LETTER_I;
    end
    return l;
  endfunction

  // Row of a row-major cell index.
  function automatic coord_t cell_row(input cell_t p);
    coord_t r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Column: index minus five times the row.
  function automatic coord_t cell_col(input cell_t p);
    coord_t r;
    cell_t  base;
    r    = cell_row(p);
    base = ({2'b00, r} << 2) + {2'b00, r};
    return coord_t'(p - base);
  endfunction

  // One step along a row or column, wrapping at the square's side.
  function automatic coord_t wrap_step(input coord_t x, input logic back);
    coord_t y;
    if (back) begin
      y = (x == 3'd0) ? coord_t'(SIDE - 1) : x - 3'd1;
    end else begin
      y = (x == coord_t'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    end
    return y;
  endfunction

  // Row-major index from row and column.
  function automatic cell_t cell_index(input coord_t r, input coord_t c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pf_if.sv @@
// ---------------------------------------------------------------------------
// pf_in_if / pf_out_if
// Valid/ready channels for input beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface pf_in_if;
  import pf_pkg::*;

  logic    valid;
  logic    ready;
  logic [1:0] cmd;
  letter_t letter_a;
  letter_t letter_b;
  logic    key_last;

  modport source (output valid, cmd, letter_a, letter_b, key_last, input ready);
  modport sink   (input valid, cmd, letter_a, letter_b, key_last, output ready);
endinterface

interface pf_out_if;
  import pf_pkg::*;

  logic    valid;
  logic    ready;
  letter_t out_a;
  letter_t out_b;
  logic    key_missing;

  modport source (output valid, out_a, out_b, key_missing, input ready);
  modport sink   (input valid, out_a, out_b, key_missing, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/playfair_digraph_cipher.sv @@
// ---------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair key-square builder and digraph encipher/decipher engine.
// ---------------------------------------------------------------------------
// Key letters are taken one beat per cycle while in_ready is high and
// written straight into the square memory and the letter-position memory.
// The beat marked key_last then starts a walk over a..z that places the
// unused letters; the input is held off during that walk. A cipher pair
// reads both letter positions from the position memory in the cycle it is
// accepted, reads the two output cells from the square memory in the next
// cycle, and then loads the result register once the result slot is free,
// in the same cycle in which the next beat can be taken; no new beat is
// taken before that. A pair sent before the square is complete returns
// key_missing with zero letters. Command code 3 is dropped without result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "playfair_digraph_cipher_defines.svh"

module playfair_digraph_cipher (
  input wire logic clk,
  input wire logic rst_n,
  pf_in_if.sink    in_ch,
  pf_out_if.source out_ch
);
  import pf_pkg::*;

  state_t         state_r, state_nxt;
  logic [25:0]    letter_used_r, letter_used_nxt;
  cell_t          fill_count_r, fill_count_nxt;
  logic           square_ready_r, square_ready_nxt;
  letter_t        fill_letter_r, fill_letter_nxt;
  logic           dec_r, missing_r;
  logic           out_valid_r, out_valid_nxt;
  letter_t        out_a_r, out_b_r;
  logic           out_missing_r;

  logic           in_ready, accept, slot_free, load_out;
  cmd_t           in_cmd;
  letter_t        a_n, b_n;
  logic           key_beat, cipher_beat, fill_step;
  logic           place_act, place_en;
  letter_t        place_letter;
  logic [25:0]    used_base;
  cell_t          fill_base;
  logic           pos_rd_en, ks_rd_en;
  cell_t          pos_a, pos_b, cell_a, cell_b;
  letter_t        ks_a, ks_b;

  // Input decode
  assign in_cmd      = cmd_t'(in_ch.cmd);
  assign a_n         = norm_letter(in_ch.letter_a);
  assign b_n         = norm_letter(in_ch.letter_b);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ready;
  assign key_beat    = accept && (in_cmd == CMD_KEY);
  assign cipher_beat = accept && ((in_cmd == CMD_ENC) || (in_cmd == CMD_DEC));
  assign fill_step   = (state_r == ST_FILL);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_SQ: begin
        if (state_r == ST_SQ && slot_free) begin
          state_nxt = ST_IDLE;
        end
        if (accept) begin
          case (in_cmd)
            CMD_KEY: state_nxt = in_ch.key_last ? ST_FILL : ST_IDLE;
            CMD_ENC, CMD_DEC: state_nxt = square_ready_r ? ST_POS : ST_SQ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_letter_r == LETTER_Z) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POS:  state_nxt = ST_SQ;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State-driven controls
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    ks_rd_en = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SQ: begin
        in_ready = slot_free;
        load_out = slot_free;
      end
      ST_POS:  ks_rd_en = 1'b1;
      ST_FILL: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  assign pos_rd_en = cipher_beat && square_ready_r;

  // Letter placement: a key beat restarts the square if it was complete
  always_comb begin
    place_act    = key_beat || fill_step;
    place_letter = fill_step ? fill_letter_r : a_n;
    used_base    = (key_beat && square_ready_r) ? '0 : letter_used_r;
    fill_base    = (key_beat && square_ready_r) ? '0 : fill_count_r;
    place_en     = place_act && !used_base[place_letter] && (fill_base < cell_t'(CELLS))
                   && !(fill_step && (fill_letter_r == LETTER_J));
    letter_used_nxt = letter_used_r;
    fill_count_nxt  = fill_count_r;
    if (place_act) begin
      letter_used_nxt = used_base | (place_en ? (26'd1 << place_letter) : 26'd0);
      fill_count_nxt  = fill_base + (place_en ? 5'd1 : 5'd0);
    end
  end

  // Readiness and fill walk
  always_comb begin
    square_ready_nxt = square_ready_r;
    fill_letter_nxt  = fill_letter_r;
    if (key_beat) begin
      square_ready_nxt = 1'b0;
      fill_letter_nxt  = '0;
    end
    if (fill_step) begin
      fill_letter_nxt = fill_letter_r + 5'd1;
      if (fill_letter_r == LETTER_Z) begin
        square_ready_nxt = 1'b1;
      end
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      letter_used_r  <= '0;
      fill_count_r   <= '0;
      square_ready_r <= 1'b0;
      fill_letter_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      letter_used_r  <= letter_used_nxt;
      fill_count_r   <= fill_count_nxt;
      square_ready_r <= square_ready_nxt;
      fill_letter_r  <= fill_letter_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Pair context and result payload
  always_ff @(posedge clk) begin
    if (cipher_beat) begin
      dec_r     <= (in_cmd == CMD_DEC);
      missing_r <= !square_ready_r;
    end
    if (load_out) begin
      out_a_r       <= missing_r ? '0 : ks_a;
      out_b_r       <= missing_r ? '0 : ks_b;
      out_missing_r <= missing_r;
    end
  end

  // Key square: cell -> letter
  pf_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_square (
    .clk      (clk),
    .wr_en    (place_en),
    .wr_addr  (fill_base),
    .wr_data  (place_letter),
    .rd_en    (ks_rd_en),
    .rd_addr0 (cell_a),
    .rd_addr1 (cell_b),
    .rd_data0 (ks_a),
    .rd_data1 (ks_b)
  );

  // Letter position: letter -> cell
  pf_ram #(.WIDTH(LETTER_W), .DEPTH(LETTERS)) u_position (
    .clk      (clk),
    .wr_en    (place_en),
    .wr_addr  (place_letter),
    .wr_data  (fill_base),
    .rd_en    (pos_rd_en),
    .rd_addr0 (a_n),
    .rd_addr1 (b_n),
    .rd_data0 (pos_a),
    .rd_data1 (pos_b)
  );

  // Output cell selection
  pf_pair_xform u_xform (
    .pos_a    (pos_a),
    .pos_b    (pos_b),
    .decipher (dec_r),
    .cell_a   (cell_a),
    .cell_b   (cell_b)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_a       = out_a_r;
  assign out_ch.out_b       = out_b_r;
  assign out_ch.key_missing = out_missing_r;

  // Checks
  `PF_ASSERT_HOLDS(a_used_count, clk, rst_n, $countones(letter_used_r) == fill_count_r, "used bits disagree with fill count")
  `PF_ASSERT_IMPLIES(a_ready_full, clk, rst_n, square_ready_r, fill_count_r == cell_t'(CELLS), "square ready but not full")
  `PF_ASSERT_HOLDS(a_no_j, clk, rst_n, !letter_used_r[LETTER_J], "letter j placed in square")
  `PF_ASSERT_IMPLIES(a_fill_stall, clk, rst_n, state_r == ST_FILL, !in_ready, "input taken during fill walk")
  `PF_ASSERT_IMPLIES(a_missing_zero, clk, rst_n, out_valid_r && out_missing_r, out_a_r == '0 && out_b_r == '0, "missing-key result carries letters")

endmodule

`default_nettype wire

@@ hw/rtl/pf_ram.sv @@
// ---------------------------------------------------------------------------
// pf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic      [WIDTH-1:0]         rd_data0,
  output logic      [WIDTH-1:0]         rd_data1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pf_pair_xform.sv @@
// ---------------------------------------------------------------------------
// pf_pair_xform
// Maps the square positions of a letter pair to the cells of the output pair.
// ---------------------------------------------------------------------------
`default_nettype none

module pf_pair_xform (
  input  wire pf_pkg::cell_t pos_a,
  input  wire pf_pkg::cell_t pos_b,
  input  wire logic          decipher,
  output pf_pkg::cell_t      cell_a,
  output pf_pkg::cell_t      cell_b
);
  import pf_pkg::*;

  coord_t ra, ca, rb, cb;

  // Split positions into row and column
  always_comb begin
    ra = cell_row(pos_a);
    ca = cell_col(pos_a);
    rb = cell_row(pos_b);
    cb = cell_col(pos_b);
  end

  // Same column: shift rows; same row: shift columns; else swap columns
  always_comb begin
    if (ca == cb) begin
      cell_a = cell_index(wrap_step(ra, decipher), ca);
      cell_b = cell_index(wrap_step(rb, decipher), cb);
    end else if (ra == rb) begin
      cell_a = cell_index(ra, wrap_step(ca, decipher));
      cell_b = cell_index(rb, wrap_step(cb, decipher));
    end else begin
      cell_a = cell_index(ra, cb);
      cell_b = cell_index(rb, ca);
    end
  end

endmodule

`default_nettype wire

@@ test/playfair_digraph_cipher_tb.sv @@
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_tb
// Self-checking bench for the Playfair key-square builder and pair cipher.
// Key and pair beats go in over the input channel with bursty pacing. A
// behavioral copy of the square predicts every result. Results are drained
// through a stalling receiver and checked in order, field by field.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    letter_t out_a;
    letter_t out_b;
    logic    key_missing;
  } pair_res_t;

  logic clk = 1'b0;
  logic rst_n;

  pf_in_if  in_ch ();
  pf_out_if out_ch ();

  playfair_digraph_cipher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // Predicted key square and the results still owed by the block
  letter_t        exp_square [CELLS];
  cell_t          exp_pos    [LETTERS];
  logic [25:0]    exp_used;
  int             exp_fill;
  bit             exp_ready;
  pair_res_t      pending_pairs [$];

  // Pacing controls
  bit gaps_on;
  int burst_left;
  bit rx_stalls_on;
  int hold_request;
  int hold_left;

  // Run statistics
  int n_errors;
  int n_checked;
  int n_key_beats;
  int n_pairs;
  int n_missing;
  int n_ignored;
  int cycle_count;

  // Codes above z read as z, j reads as i
  function automatic letter_t fold_letter(input logic [4:0] raw);
    if (raw >= 5'd26) return LETTER_Z;
    if (raw == LETTER_J) return LETTER_I;
    return raw;
  endfunction

  // Take the next free cell unless the letter is already placed
  function automatic void place_in_square(input letter_t l);
    if (exp_fill >= CELLS || exp_used[l]) return;
    exp_square[exp_fill] = l;
    exp_pos[l]           = cell_t'(exp_fill);
    exp_used[l]          = 1'b1;
    exp_fill++;
  endfunction

  // Update the predicted square for one accepted beat, queue its result
  function automatic void playfair_predict(input cmd_t cmd, input logic [4:0] raw_a,
                                           input logic [4:0] raw_b, input logic key_end);
    letter_t   a;
    letter_t   b;
    int        ra, ca, rb, cb, step;
    pair_res_t r;
    a = fold_letter(raw_a);
    b = fold_letter(raw_b);
    case (cmd)
      CMD_KEY: begin
        n_key_beats++;
        // a key letter after a finished square starts over
        if (exp_ready) begin
          exp_used  = '0;
          exp_fill  = 0;
          exp_ready = 1'b0;
        end
        place_in_square(a);
        if (key_end) begin
          for (int l = 0; l < LETTERS; l++) begin
            if (l != int'(LETTER_J)) place_in_square(letter_t'(l));
          end
          exp_ready = 1'b1;
        end
      end
      CMD_ENC, CMD_DEC: begin
        n_pairs++;
        if (!exp_ready) begin
          n_missing++;
          r = '{out_a: '0, out_b: '0, key_missing: 1'b1};
        end else begin
          ra   = int'(exp_pos[a]) / SIDE;
          ca   = int'(exp_pos[a]) % SIDE;
          rb   = int'(exp_pos[b]) / SIDE;
          cb   = int'(exp_pos[b]) % SIDE;
          step = (cmd == CMD_ENC) ? 1 : SIDE - 1;
          if (ca == cb) begin
            r.out_a = exp_square[((ra + step) % SIDE) * SIDE + ca];
            r.out_b = exp_square[((rb + step) % SIDE) * SIDE + cb];
          end else if (ra == rb) begin
            r.out_a = exp_square[ra * SIDE + (ca + step) % SIDE];
            r.out_b = exp_square[rb * SIDE + (cb + step) % SIDE];
          end else begin
            r.out_a = exp_square[ra * SIDE + cb];
            r.out_b = exp_square[rb * SIDE + ca];
          end
          r.key_missing = 1'b0;
        end
        pending_pairs.push_back(r);
      end
      default: n_ignored++;
    endcase
  endfunction

  // Sender pacing: random bursts separated by random gaps
  task automatic pace_sender();
    if (!gaps_on) return;
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Offer one beat and hold it until the block takes it
  task automatic send_beat(input cmd_t cmd, input logic [4:0] a, input logic [4:0] b,
                           input logic key_end);
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.letter_a <= a;
    in_ch.letter_b <= b;
    in_ch.key_last <= key_end;
    do @(posedge clk); while (!in_ch.ready);
    playfair_predict(cmd, a, b, key_end);
    pace_sender();
  endtask

  // Stop sending until every owed result is back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  // Random raw letter, leaning on j and the codes past z now and then
  function automatic logic [4:0] random_raw_letter();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 5'($urandom_range(26, 31));
    if (sel == 1) return LETTER_J;
    return 5'($urandom_range(0, 25));
  endfunction

  // Re-spell i as j or z as an out-of-range code at random
  function automatic logic [4:0] disguise(input letter_t l);
    if (l == LETTER_I && $urandom_range(0, 1) == 1) return LETTER_J;
    if (l == LETTER_Z && $urandom_range(0, 1) == 1) return 5'($urandom_range(26, 31));
    return l;
  endfunction

  task automatic send_random_pair();
    letter_t  a;
    letter_t  b;
    int       sel, pos;
    cmd_t     cmd;
    cmd = ($urandom_range(0, 1) == 1) ? CMD_ENC : CMD_DEC;
    sel = $urandom_range(0, 5);
    a   = fold_letter(5'($urandom_range(0, 25)));
    b   = fold_letter(random_raw_letter());
    // steer toward same-row, same-column and equal pairs
    if (exp_ready && sel < 3) begin
      pos = int'(exp_pos[a]);
      case (sel)
        0:       b = exp_square[(pos / SIDE) * SIDE + $urandom_range(0, SIDE - 1)];
        1:       b = exp_square[$urandom_range(0, SIDE - 1) * SIDE + pos % SIDE];
        default: b = a;
      endcase
    end
    send_beat(cmd, disguise(a), disguise(b), 1'($urandom_range(0, 1)));
  endtask

  // Random key: short words mostly, sometimes a bare end beat or the full alphabet
  task automatic send_random_key();
    int sel, len;
    int perm [26];
    int k, j, t;
    sel = $urandom_range(0, 9);
    for (k = 0; k < 26; k++) perm[k] = k;
    for (k = 25; k > 0; k--) begin
      j       = $urandom_range(0, k);
      t       = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
    len = (sel == 0) ? 26 : (sel == 1) ? 1 : $urandom_range(2, 12);
    for (k = 0; k < len; k++) begin
      if (sel == 0) begin
        send_beat(CMD_KEY, 5'(perm[k]), 5'($urandom_range(0, 31)), k == len - 1);
      end else begin
        send_beat(CMD_KEY, random_raw_letter(), 5'($urandom_range(0, 31)), k == len - 1);
      end
      if (k < len - 1) begin
        // pairs in the middle of a key see an unfinished square
        if ($urandom_range(0, 11) == 0) send_random_pair();
        if ($urandom_range(0, 14) == 0) begin
          send_beat(CMD_NOP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // Pairs before any key come back flagged; the unused code is dropped
  task automatic test_missing_key();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b0;
    send_beat(CMD_ENC, 5'd0, 5'd25, 1'b0);
    send_beat(CMD_DEC, 5'd31, LETTER_J, 1'b1);
    send_beat(CMD_NOP, 5'd31, 5'd31, 1'b1);
  endtask

  // Key with repeats, j and codes past z; then each pair geometry, rows and columns both ways
  task automatic test_key_and_pairs();
    int key_word [10] = '{15, 11, 0, 24, 5, 9, 17, 0, 4, 30};
    rx_stalls_on = 1'b1;
    for (int k = 0; k < 10; k++) send_beat(CMD_KEY, 5'(key_word[k]), 5'd0, k == 9);
    send_beat(CMD_ENC, 5'd15, 5'd0, 1'b0);   // same row
    send_beat(CMD_DEC, 5'd15, 5'd0, 1'b1);
    send_beat(CMD_ENC, 5'd11, 5'd17, 1'b0);  // same column
    send_beat(CMD_DEC, 5'd11, 5'd17, 1'b0);
    send_beat(CMD_ENC, 5'd0, 5'd7, 1'b0);    // rectangle
    send_beat(CMD_ENC, 5'd23, 5'd23, 1'b0);  // equal letters
    send_beat(CMD_DEC, LETTER_J, 5'd31, 1'b0);
    send_beat(CMD_ENC, 5'd26, 5'd25, 1'b1);
  endtask

  // A key letter on a finished square starts a fresh key
  task automatic test_rekey();
    gaps_on    = 1'b1;
    burst_left = 2;
    send_beat(CMD_KEY, 5'd0, 5'd31, 1'b1);
    send_beat(CMD_DEC, 5'd0, 5'd0, 1'b0);
    send_beat(CMD_ENC, 5'd25, 5'd20, 1'b0);
    send_beat(CMD_NOP, 5'd0, 5'd0, 1'b0);
    wait_results_drained();
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (30) send_random_pair();
    wait_results_drained();
  endtask

  // Random keys, each followed by a run of random pairs
  task automatic test_random_traffic();
    int base;
    int n_seq;
    base  = n_key_beats + n_pairs;
    n_seq = 0;
    while (n_key_beats + n_pairs - base < RANDOM_ITEMS) begin
      gaps_on      = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      send_random_key();
      repeat ($urandom_range(4, 30)) begin
        send_random_pair();
        if ($urandom_range(0, 19) == 0) begin
          send_beat(CMD_NOP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)));
        end
      end
      n_seq++;
      if (n_seq == 10) wait_results_drained();
    end
  endtask

  // Receiver: ready on its own run-length pattern, plus a requested hold-off
  initial begin
    int  run_left;
    bit  stalling;
    out_ch.ready <= 1'b0;
    run_left = 0;
    stalling = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!rx_stalls_on) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, 5) : $urandom_range(1, 10);
        end
        run_left--;
        out_ch.ready <= !stalling;
      end
    end
  end

  // Result check against the oldest owed result
  always @(posedge clk) begin
    pair_res_t got;
    pair_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_a: out_ch.out_a, out_b: out_ch.out_b, key_missing: out_ch.key_missing};
      if (pending_pairs.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("[%0t] unexpected result beat: a=%0d b=%0d key_missing=%0b",
                   $realtime, got.out_a, got.out_b, got.key_missing);
        end
      end else begin
        want = pending_pairs.pop_front();
        n_checked++;
        if (got.out_a !== want.out_a || got.out_b !== want.out_b ||
            got.key_missing !== want.key_missing) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("[%0t] result mismatch: expected a=%0d b=%0d key_missing=%0b, got a=%0d b=%0d key_missing=%0b",
                     $realtime, want.out_a, want.out_b, want.key_missing,
                     got.out_a, got.out_b, got.key_missing);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_pairs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_NOP;
    in_ch.letter_a <= '0;
    in_ch.letter_b <= '0;
    in_ch.key_last <= 1'b0;
    rst_n          <= 1'b0;
    exp_used     = '0;
    exp_fill     = 0;
    exp_ready    = 1'b0;
    gaps_on      = 1'b0;
    burst_left   = 1;
    rx_stalls_on = 1'b0;
    hold_request = 0;
    hold_left    = 0;
    n_errors     = 0;
    n_checked    = 0;
    n_key_beats  = 0;
    n_pairs      = 0;
    n_missing    = 0;
    n_ignored    = 0;
    cycle_count  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_missing_key();
    test_key_and_pairs();
    test_rekey();
    test_backpressure();
    test_random_traffic();

    // let the last results and any trailing fill walk finish
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d key beats, %0d cipher pairs (%0d without a finished square), %0d dropped",
             n_key_beats, n_pairs, n_missing, n_ignored);
    $display("Checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
